FILE: sv/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int SEQ_W            = 3;
  localparam int DATA_BITS        = 64;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int SEQ_SPACE        = 1 << SEQ_W;
  localparam int QUEUE_DEPTH      = 2;

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [DATA_BITS-1:0] data_t;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [2:0] EV_NEW     = 3'd0;
  localparam logic [2:0] EV_REFUSED = 3'd1;
  localparam logic [2:0] EV_RESENT  = 3'd2;
  localparam logic [2:0] EV_ACK_OK  = 3'd3;
  localparam logic [2:0] EV_ACK_IGN = 3'd4;
  localparam logic [2:0] EV_IDLE_TO = 3'd5;

  localparam logic [1:0] TA_NONE    = 2'd0;
  localparam logic [1:0] TA_START   = 2'd1;
  localparam logic [1:0] TA_STOP    = 2'd2;
  localparam logic [1:0] TA_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    data_t      payload;
    seq_t       ack_number;
    logic       ack_intact;
    seq_t       timeout_seq;
  } gbn_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    seq_t       seq_number;
    data_t      packet_data;
    logic [1:0] timer_action;
    seq_t       timer_stop_seq;
    seq_t       timer_start_seq;
    seq_t       outstanding;
    logic       last;
  } gbn_out_t;

  typedef struct packed {
    logic [2:0] event_res;
    seq_t       seq_number;
    data_t      data;
    logic [1:0] timer_action;
    seq_t       stop_seq;
    seq_t       start_seq;
    seq_t       outstanding;
  } gbn_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } gbn_qstat_t;

endpackage

FILE: sv/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front import gbn_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  gbn_in_t  req,
  output logic     push,
  output gbn_job_t job
);

  localparam data_t DMASK  = {DATA_BITS{1'b1}} >> (DATA_BITS - PAYLOAD_BITS);
  localparam seq_t  WINDOW = {SEQ_W{1'b1}};

  seq_t base_r, base_nxt;
  seq_t last_r, last_nxt;
  seq_t cnt_r, cnt_nxt;
  seq_t seq_new;
  seq_t ack_off;

  always_comb begin
    base_nxt = base_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    job      = '0;
    seq_new  = last_r + 1'b1;
    ack_off  = req.ack_number - base_r;
    if (accept) begin
      case (req.cmd)
        CMD_SEND: begin
          push = 1'b1;
          if (cnt_r >= WINDOW) begin
            job.event_res   = EV_REFUSED;
            job.seq_number  = seq_new;
            job.outstanding = cnt_r;
          end else begin
            last_nxt        = seq_new;
            cnt_nxt         = cnt_r + 1'b1;
            job.event_res   = EV_NEW;
            job.seq_number  = seq_new;
            job.data        = req.payload & DMASK;
            job.outstanding = cnt_nxt;
            if (base_r == seq_new) begin
              job.timer_action = TA_START;
              job.start_seq    = base_r;
            end
          end
        end
        CMD_ACK: begin
          push = 1'b1;
          if (req.ack_intact && (ack_off < cnt_r)) begin
            base_nxt        = req.ack_number + 1'b1;
            cnt_nxt         = cnt_r - ack_off - 1'b1;
            job.event_res   = EV_ACK_OK;
            job.seq_number  = base_nxt;
            job.stop_seq    = base_r;
            job.outstanding = cnt_nxt;
            if (cnt_nxt == '0) begin
              job.timer_action = TA_STOP;
            end else begin
              job.timer_action = TA_RESTART;
              job.start_seq    = base_nxt;
            end
          end else begin
            job.event_res   = EV_ACK_IGN;
            job.seq_number  = base_r;
            job.outstanding = cnt_r;
          end
        end
        CMD_TIMEOUT: begin
          push             = 1'b1;
          job.event_res    = (cnt_r == '0) ? EV_IDLE_TO : EV_RESENT;
          job.seq_number   = base_r;
          job.timer_action = TA_RESTART;
          job.stop_seq     = req.timeout_seq;
          job.start_seq    = req.timeout_seq;
          job.outstanding  = cnt_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      last_r <= '1;
      cnt_r  <= '0;
    end else begin
      base_r <= base_nxt;
      last_r <= last_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/gbn_queue.sv
`timescale 1ns / 1ps

module gbn_queue import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gbn_job_t   job_in,
  input  logic       pop,
  output gbn_job_t   job_out,
  output gbn_qstat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  gbn_job_t entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= job_in;
    end
  end

  assign job_out    = entry_r[rptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);

endmodule

FILE: sv/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back import gbn_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  gbn_qstat_t qstat,
  input  gbn_job_t   job,
  output logic       pop,
  output logic       out_strobe,
  output gbn_out_t   out_res
);

  logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  logic     burst_r, burst_nxt;
  seq_t     k_r, k_nxt;
  gbn_job_t cur_r, cur_nxt;
  logic     strobe_r, strobe_nxt;
  gbn_out_t res_r, res_nxt;
  logic     from_mem_r, from_mem_nxt;
  logic     rd_en;
  logic     wr_en;
  seq_t     rd_addr;

  always_comb begin
    burst_nxt    = burst_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    strobe_nxt   = 1'b0;
    res_nxt      = res_r;
    from_mem_nxt = 1'b0;
    pop          = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    rd_addr      = cur_r.seq_number + k_r;
    if (burst_r) begin
      rd_en                   = 1'b1;
      strobe_nxt              = 1'b1;
      from_mem_nxt            = 1'b1;
      res_nxt                 = '0;
      res_nxt.event_res       = EV_RESENT;
      res_nxt.seq_number      = rd_addr;
      res_nxt.timer_action    = TA_NONE;
      res_nxt.outstanding     = cur_r.outstanding;
      res_nxt.last            = (k_r == cur_r.outstanding - 1'b1);
      k_nxt                   = k_r + 1'b1;
      if (res_nxt.last) begin
        burst_nxt = 1'b0;
      end
    end else if (!qstat.empty) begin
      pop                     = 1'b1;
      strobe_nxt              = 1'b1;
      res_nxt.event_res       = job.event_res;
      res_nxt.seq_number      = job.seq_number;
      res_nxt.packet_data     = job.data;
      res_nxt.timer_action    = job.timer_action;
      res_nxt.timer_stop_seq  = job.stop_seq;
      res_nxt.timer_start_seq = job.start_seq;
      res_nxt.outstanding     = job.outstanding;
      res_nxt.last            = 1'b1;
      if (job.event_res == EV_NEW) begin
        wr_en = 1'b1;
      end
      if (job.event_res == EV_RESENT) begin
        rd_en        = 1'b1;
        rd_addr      = job.seq_number;
        from_mem_nxt = 1'b1;
        res_nxt.last = (job.outstanding == seq_t'(1));
        cur_nxt      = job;
        k_nxt        = seq_t'(1);
        burst_nxt    = (job.outstanding != seq_t'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      burst_r  <= burst_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    from_mem_r <= from_mem_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[job.seq_number] <= job.data[PAYLOAD_BITS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_res = res_r;
    if (from_mem_r) begin
      out_res.packet_data = DATA_BITS'(rd_data_r);
    end
  end

  assign out_strobe = strobe_r;

endmodule

FILE: sv/go_back_n_sender.sv
`timescale 1ns / 1ps

// Go-Back-N sender with a window of seven packets over 3-bit sequence numbers.
// A request is taken at a rising edge where start is high and busy is low. It carries
// a command (send, acknowledgement or timer expiry) with its payload fields.
// Each defined command yields one result, but a timeout with packets outstanding
// yields one resent packet per outstanding packet, oldest first, with last set on
// the final one. Results appear on out_res for one cycle each, marked by out_strobe.
// After acceptance a result passes through the request queue and the output register.
// Window state is updated when the request is taken, so send and acknowledgement
// requests are taken one per cycle while busy is low. Results are produced at one
// per cycle, so a timeout burst of n packets keeps the result side occupied until its
// last packet, and busy rises once the two-entry request queue fills behind it.
// The receiver cannot stall: every strobed result is taken in its cycle.
// Reset clears the window, empties the queue and drops any burst in progress.
// The packet store holds no defined data until a send writes an entry.
module go_back_n_sender import gbn_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gbn_in_t  in_req,
  output logic     out_strobe,
  output gbn_out_t out_res
);

  logic       accept;
  logic       push;
  logic       pop;
  gbn_job_t   job_in;
  gbn_job_t   job_out;
  gbn_qstat_t qstat;

  assign busy   = qstat.full;
  assign accept = start && !busy;

  gbn_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req),
    .push   (push),
    .job    (job_in)
  );

  gbn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .stat    (qstat)
  );

  gbn_back #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .job        (job_out),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

FILE: sv/gbn_checker.sv
`timescale 1ns / 1ps

module gbn_checker import gbn_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_strobe,
  input gbn_out_t out_res
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("busy or strobe after reset");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.event_res == EV_RESENT && !out_res.last |=>
      out_strobe && out_res.event_res == EV_RESENT &&
      out_res.seq_number == seq_t'($past(out_res.seq_number) + 1'b1))
    else $error("resend burst broken");

  a_only_burst_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last |-> out_res.event_res == EV_RESENT)
    else $error("non-final result outside a resend burst");

  a_new_has_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.event_res == EV_NEW |-> out_res.outstanding != '0)
    else $error("new packet with nothing outstanding");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);

FILE: tb/tb_go_back_n_sender.sv
`timescale 1ns / 1ps

module tb_go_back_n_sender;
  import gbn_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WINDOW_SIZE     = SEQ_SPACE - 1;
  localparam int RANDOM_REQUESTS = 340;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    gbn_in_t  req;
    logic     fixed_result;
    gbn_out_t want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  gbn_in_t  in_req = '0;
  logic     out_strobe;
  gbn_out_t out_res;

  seq_t      window_base;
  seq_t      last_sent;
  int        in_flight;
  data_t     payload_store [SEQ_SPACE];
  gbn_out_t  results_due [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        allow_gaps = 1'b1;

  go_back_n_sender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic data_t random_data();
    return {$urandom(), $urandom()};
  endfunction

  function automatic gbn_in_t req_of(logic [1:0] cmd, data_t payload, seq_t ack_number,
                                     logic ack_intact, seq_t timeout_seq);
    return gbn_in_t'{cmd, payload, ack_number, ack_intact, timeout_seq};
  endfunction

  function automatic gbn_out_t res_of(logic [2:0] ev, seq_t seq, data_t data,
                                      logic [1:0] act, seq_t stop_seq, seq_t start_seq,
                                      seq_t outs);
    return gbn_out_t'{ev, seq, data, act, stop_seq, start_seq, outs, 1'b1};
  endfunction

  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic void queue_result(gbn_out_t res);
    results_due.insert(results_due.size(), res);
  endfunction

  // Applies one accepted request to the window and queues the results it causes.
  function automatic void advance_window(gbn_in_t r);
    gbn_out_t res;
    seq_t     nxt;
    seq_t     old_base;
    int       hit;
    res = '0;
    res.last = 1'b1;
    case (r.cmd)
      CMD_SEND: begin
        nxt = last_sent + 1'b1;
        res.seq_number = nxt;
        if (in_flight >= WINDOW_SIZE) begin
          res.event_res = EV_REFUSED;
        end else begin
          last_sent = nxt;
          payload_store[nxt] = r.payload;
          in_flight++;
          res.event_res = EV_NEW;
          res.packet_data = r.payload;
          if (window_base == nxt) begin
            res.timer_action = TA_START;
            res.timer_start_seq = nxt;
          end
        end
        res.outstanding = seq_t'(in_flight);
        queue_result(res);
      end
      CMD_ACK: begin
        hit = 0;
        if (r.ack_intact) begin
          for (int k = 0; k < in_flight; k++) begin
            if (hit == 0 && seq_t'(window_base + k) == r.ack_number) hit = k + 1;
          end
        end
        if (hit == 0) begin
          res.event_res = EV_ACK_IGN;
        end else begin
          old_base = window_base;
          window_base = seq_t'(window_base + hit);
          in_flight -= hit;
          res.event_res = EV_ACK_OK;
          res.timer_action = (in_flight == 0) ? TA_STOP : TA_RESTART;
          res.timer_stop_seq = old_base;
          if (in_flight != 0) res.timer_start_seq = window_base;
        end
        res.seq_number = window_base;
        res.outstanding = seq_t'(in_flight);
        queue_result(res);
      end
      CMD_TIMEOUT: begin
        res.outstanding = seq_t'(in_flight);
        res.timer_action = TA_RESTART;
        res.timer_stop_seq = r.timeout_seq;
        res.timer_start_seq = r.timeout_seq;
        if (in_flight == 0) begin
          res.event_res = EV_IDLE_TO;
          res.seq_number = window_base;
          queue_result(res);
        end else begin
          for (int k = 0; k < in_flight; k++) begin
            res.event_res = EV_RESENT;
            res.seq_number = seq_t'(window_base + k);
            res.packet_data = payload_store[seq_t'(window_base + k)];
            res.last = (k == in_flight - 1);
            queue_result(res);
            res.timer_action = TA_NONE;
            res.timer_stop_seq = '0;
            res.timer_start_seq = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly sends and acknowledgements, with some stale or damaged acknowledgements.
  function automatic gbn_in_t random_request();
    gbn_in_t r;
    int      pick;
    pick = $urandom_range(99);
    r.payload = random_data();
    if ($urandom_range(7) == 0) r.payload = $urandom_range(1) ? '1 : '0;
    r.ack_number = $urandom_range(7);
    r.ack_intact = ($urandom_range(99) < 88);
    r.timeout_seq = $urandom_range(7);
    if (pick < 48) begin
      r.cmd = CMD_SEND;
    end else if (pick < 85) begin
      r.cmd = CMD_ACK;
      if (in_flight > 0 && $urandom_range(99) < 80)
        r.ack_number = seq_t'(window_base + $urandom_range(in_flight - 1));
    end else if (pick < 96) begin
      r.cmd = CMD_TIMEOUT;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  task automatic issue_request(gbn_in_t r, logic fixed_result, gbn_out_t want);
    int gap;
    gap = 0;
    if (allow_gaps) begin
      while ($urandom_range(99) < 38) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    advance_window(r);
    if (fixed_result) begin
      results_due[results_due.size() - 1] = want;
    end
  endtask

  task automatic await_quiet();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    gbn_out_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: %0h", out_res);
        mismatches++;
      end else begin
        want = results_due[0];
        results_due.delete(0);
        check_field("event_res", 64'(want.event_res), 64'(out_res.event_res));
        check_field("seq_number", 64'(want.seq_number), 64'(out_res.seq_number));
        check_field("packet_data", want.packet_data, out_res.packet_data);
        check_field("timer_action", 64'(want.timer_action), 64'(out_res.timer_action));
        check_field("timer_stop_seq", 64'(want.timer_stop_seq),
                    64'(out_res.timer_stop_seq));
        check_field("timer_start_seq", 64'(want.timer_start_seq),
                    64'(out_res.timer_start_seq));
        check_field("outstanding", 64'(want.outstanding), 64'(out_res.outstanding));
        check_field("last", 64'(want.last), 64'(out_res.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    gbn_in_t   r;
    int        issued;
    window_base = '0;
    last_sent = '1;
    in_flight = 0;

    add_row(plan_row_t'{req_of(CMD_TIMEOUT, '0, 0, 1'b1, 7), 1'b1,
                        res_of(EV_IDLE_TO, 0, '0, TA_RESTART, 7, 7, 0)});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 0, 1'b1, 0), 1'b1,
                        res_of(EV_ACK_IGN, 0, '0, TA_NONE, 0, 0, 0)});
    add_row(plan_row_t'{req_of(CMD_UNUSED, '1, 7, 1'b1, 7), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, '1, 0, 1'b0, 0), 1'b1,
                        res_of(EV_NEW, 0, '1, TA_START, 0, 0, 1)});
    add_row(plan_row_t'{req_of(CMD_SEND, '0, 7, 1'b1, 7), 1'b1,
                        res_of(EV_NEW, 1, '0, TA_NONE, 0, 0, 2)});
    add_row(plan_row_t'{req_of(CMD_SEND, 64'haaaa_aaaa_aaaa_aaaa, 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, 64'h5555_5555_5555_5555, 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, 64'h1, 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, 64'h8000_0000_0000_0000, 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b1,
                        res_of(EV_REFUSED, 7, '0, TA_NONE, 0, 0, 7)});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 2, 1'b0, 0), 1'b1,
                        res_of(EV_ACK_IGN, 0, '0, TA_NONE, 0, 0, 7)});
    add_row(plan_row_t'{req_of(CMD_TIMEOUT, '0, 0, 1'b0, 5), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 2, 1'b1, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 1, 1'b1, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_TIMEOUT, '0, 0, 1'b0, 2), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 1, 1'b1, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_TIMEOUT, '0, 0, 1'b0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_UNUSED, '0, 0, 1'b0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_SEND, random_data(), 0, 0, 0), 1'b0, '0});
    add_row(plan_row_t'{req_of(CMD_ACK, '0, 2, 1'b1, 0), 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) issue_request(plan[i].req, plan[i].fixed_result, plan[i].want);
    await_quiet();

    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      allow_gaps = !(issued >= 120 && issued < 200);
      r = random_request();
      issue_request(r, 1'b0, '0);
      if (r.cmd != CMD_UNUSED) begin
        issued++;
        if (issued == 260) await_quiet();
      end
    end
    await_quiet();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
